// ===== hdl/tovl_pkg.sv =====
// tovl_pkg: shared types, constants, font and line tables for the text overlay compositor
// depends on nothing; imported by text_overlay_pixel_compositor_unit, tovl_pixel_checker and tb_top
package tovl_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int LOGO_WIDTH    = 64;
  localparam int LOGO_HEIGHT   = 32;
  localparam int LINE_COUNT    = 7;
  localparam int LINE_LENGTH   = 28;

  localparam int LOGO_CELLS     = LOGO_WIDTH * LOGO_HEIGHT;
  localparam int LOGO_ADDR_W    = $clog2(LOGO_CELLS);
  localparam int LOGO_RIGHT_GAP = 4;
  localparam int LOGO_X         = SCREEN_WIDTH - LOGO_WIDTH - LOGO_RIGHT_GAP;

  localparam int LINE_W       = $clog2(LINE_COUNT);
  localparam int SLOT_W       = $clog2(LINE_LENGTH);
  localparam int CHAR_ADDR_W  = LINE_W + SLOT_W;
  localparam int CHAR_DEPTH   = LINE_COUNT * (2 ** SLOT_W);

  localparam int CELL_COLS  = 6;
  localparam int GLYPH_COLS = 5;
  localparam int GLYPH_ROWS = 7;

  // floor(n / 6) = (n * 683) >> 12 for every 9-bit n
  localparam int RECIP_6     = 683;
  localparam int RECIP_SHIFT = 12;
  localparam int PROD_W      = 19;
  localparam int CELL_W      = PROD_W - RECIP_SHIFT;

  localparam logic [15:0] BACKGROUND_RESET = 16'h18E3;
  localparam logic [8:0]  TEXT_LEFT_RESET  = 9'd12;
  localparam logic [7:0]  LOGO_TOP_RESET   = 8'd2;

  // first row of each text line; the last one is drawn unscaled
  localparam logic [7:0] LINE_FIRST_ROW [LINE_COUNT] = '{
    8'd10, 8'd48, 8'd78, 8'd108, 8'd138, 8'd168, 8'd220
  };
  localparam int UNSCALED_LINE = 6;

  typedef enum logic [1:0] {
    OP_RENDER     = 2'd0,
    OP_WRITE_CHAR = 2'd1,
    OP_WRITE_LCOL = 2'd2,
    OP_WRITE_LOGO = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    SRC_BACKGROUND = 2'd0,
    SRC_LOGO       = 2'd1,
    SRC_TEXT       = 2'd2
  } source_t;

  typedef enum logic [1:0] {
    REG_BACKGROUND = 2'd0,
    REG_TEXT_LEFT  = 2'd1,
    REG_LOGO_TOP   = 2'd2
  } reg_index_t;

  localparam int PADDR_W = 4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  pixel_row;
    logic [8:0]  pixel_column;
    logic [2:0]  line_number;
    logic [4:0]  char_slot;
    logic [7:0]  char_code;
    logic [15:0] write_color;
    logic [10:0] logo_index;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [1:0]  pixel_source;
  } pixel_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } glyph_t;

  // font entry of a character code
  function automatic glyph_t glyph_of(input logic [7:0] code);
    glyph_t g;
    g.hit = 1'b1;
    g.idx = 6'd0;
    if (code >= 8'd45 && code <= 8'd47) begin
      g.idx = 6'(code - 8'd45);
    end else if (code == 8'd58) begin
      g.idx = 6'd3;
    end else if (code >= 8'd48 && code <= 8'd57) begin
      g.idx = 6'(code - 8'd44);
    end else if (code >= 8'd65 && code <= 8'd90) begin
      g.idx = 6'(code - 8'd51);
    end else begin
      g.hit = 1'b0;
    end
    return g;
  endfunction

  // five glyph columns, column 0 in the low byte, bit 0 is the top row
  function automatic logic [39:0] glyph_bits(input logic [5:0] g);
    logic [39:0] f;
    case (g)
      6'd0:  f = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      6'd1:  f = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
      6'd2:  f = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      6'd3:  f = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
      6'd4:  f = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
      6'd5:  f = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
      6'd6:  f = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
      6'd7:  f = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
      6'd8:  f = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
      6'd9:  f = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
      6'd10: f = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
      6'd11: f = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
      6'd12: f = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      6'd13: f = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
      6'd14: f = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      6'd15: f = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd16: f = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd17: f = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
      6'd18: f = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
      6'd19: f = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd20: f = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
      6'd21: f = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      6'd22: f = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      6'd23: f = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
      6'd24: f = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
      6'd25: f = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
      6'd26: f = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
      6'd27: f = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
      6'd28: f = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      6'd29: f = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
      6'd30: f = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
      6'd31: f = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
      6'd32: f = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
      6'd33: f = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      6'd34: f = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      6'd35: f = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      6'd36: f = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
      6'd37: f = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      6'd38: f = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      6'd39: f = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/text_overlay_pixel_compositor_unit.sv =====
// text_overlay_pixel_compositor_unit: pixel compositor with logo window and 5x7 text overlay
// depends on tovl_pkg (types, font table, line rows, screen constants)
//
// usage
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one transaction per item: a pixel
//   render request, or a write into the character store, the line colours or the logo
//   image. writes take effect at the edge at which they are accepted and produce no result
//   px channel (px_valid / px_stall / px) returns one colour and source per render
//   registers background_color, text_left and logo_top sit on the apb port at 0x0, 0x4, 0x8
// timing
//   one transaction accepted every clock unless cmd_stall is raised; a render result passes
//   through three register stages: row/column decode with the cell
//   reciprocal multiply, character and logo memory reads, font lookup and colour select
// stalls
//   px_stall against a waiting result holds the whole pipeline, including the output
//   register, and raises cmd_stall in the same cycle; with no result waiting px_stall
//   has no effect; nothing is dropped or repeated
// reset
//   rst (synchronous) empties the pipeline, loads register defaults and clears the
//   per-slot occupancy flags of the character store at once, so every line reads empty;
//   the logo image is undefined until written and has no clearing pass
module text_overlay_pixel_compositor_unit (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           cmd_valid,
  output logic                           cmd_stall,
  input  tovl_pkg::cmd_t                 cmd,
  // pixel result channel
  output logic                           px_valid,
  input  logic                           px_stall,
  output tovl_pkg::pixel_t               px,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tovl_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tovl_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] background_color;
  logic [8:0]  text_left;
  logic [7:0]  logo_top;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      background_color <= BACKGROUND_RESET;
      text_left        <= TEXT_LEFT_RESET;
      logo_top         <= LOGO_TOP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BACKGROUND: background_color <= pwdata[15:0];
        REG_TEXT_LEFT:  text_left        <= pwdata[8:0];
        REG_LOGO_TOP:   logo_top         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_BACKGROUND: prdata = {16'd0, background_color};
      REG_TEXT_LEFT:  prdata = {23'd0, text_left};
      REG_LOGO_TOP:   prdata = {24'd0, logo_top};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: one advance signal moves every stage together
  // ---------------------------------------------------------------------------
  logic adv;
  logic cmd_accept;
  logic s3_valid;

  assign adv        = !(s3_valid && px_stall);
  assign cmd_stall  = !adv;
  assign cmd_accept = cmd_valid && adv;

  // ---------------------------------------------------------------------------
  // stores; writes land at the accepting edge, reads are made from stage 1 as it moves into
  // stage 2, so a write right behind a render never overtakes it
  // ---------------------------------------------------------------------------
  logic [7:0]  char_mem [CHAR_DEPTH];
  logic [15:0] logo_mem [LOGO_CELLS];
  logic [LINE_COUNT-1:0][LINE_LENGTH-1:0] char_nz;   // slot holds a non-zero code
  logic [LINE_COUNT-1:0][15:0]            line_colors;

  logic wr_char, wr_lcol, wr_logo;

  assign wr_char = cmd_accept && (cmd.opcode == OP_WRITE_CHAR)
                   && ({1'b0, cmd.line_number} < 4'(LINE_COUNT))
                   && ({1'b0, cmd.char_slot} < 6'(LINE_LENGTH));
  assign wr_lcol = cmd_accept && (cmd.opcode == OP_WRITE_LCOL)
                   && ({1'b0, cmd.line_number} < 4'(LINE_COUNT));
  assign wr_logo = cmd_accept && (cmd.opcode == OP_WRITE_LOGO)
                   && ({1'b0, cmd.logo_index} < 12'(LOGO_CELLS));

  always_ff @(posedge clk) begin
    if (rst) begin
      char_nz     <= '0;
      line_colors <= '0;
    end else begin
      if (wr_char) begin
        char_nz[cmd.line_number][cmd.char_slot] <= (cmd.char_code != 8'd0);
      end
      if (wr_lcol) begin
        line_colors[cmd.line_number] <= cmd.write_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_char) begin
      char_mem[{cmd.line_number, cmd.char_slot}] <= cmd.char_code;
    end
    if (wr_logo) begin
      logo_mem[cmd.logo_index] <= cmd.write_color;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0 (combinational from the command): column offset with reciprocal multiply, screen, logo and line decode
  // ---------------------------------------------------------------------------
  logic                   d0_on_screen;
  logic                   d0_in_logo;
  logic [LOGO_ADDR_W-1:0] d0_logo_addr;
  logic                   d0_text_row;
  logic [LINE_W-1:0]      d0_line;
  logic                   d0_scale2;
  logic [2:0]             d0_grow;
  logic                   d0_left_of_text;
  logic [8:0]             d0_off;
  logic [PROD_W-1:0]      d0_prod;
  logic [7:0]             d0_logo_r;
  logic [8:0]             d0_logo_c;
  logic [8:0]             d0_top, d0_height, d0_rel;
  logic [8:0]             d0_div_in;

  always_comb begin
    d0_on_screen = ({1'b0, cmd.pixel_row} < 9'(SCREEN_HEIGHT))
                   && ({1'b0, cmd.pixel_column} < 10'(SCREEN_WIDTH));

    // logo window
    d0_logo_r  = cmd.pixel_row - logo_top;
    d0_logo_c  = cmd.pixel_column - 9'(LOGO_X);
    d0_in_logo = (cmd.pixel_row >= logo_top) && ({1'b0, d0_logo_r} < 9'(LOGO_HEIGHT))
                 && ({1'b0, cmd.pixel_column} >= 10'(LOGO_X))
                 && ({1'b0, d0_logo_c} < 10'(LOGO_WIDTH));
    d0_logo_addr = LOGO_ADDR_W'(d0_logo_r) * LOGO_ADDR_W'(LOGO_WIDTH)
                   + LOGO_ADDR_W'(d0_logo_c);

    // text line band; the higher line wins where bands meet
    d0_text_row = 1'b0;
    d0_line     = '0;
    d0_scale2   = 1'b1;
    d0_grow     = '0;
    for (int l = 0; l < LINE_COUNT; l++) begin
      d0_top    = {1'b0, LINE_FIRST_ROW[l]};
      d0_height = (l == UNSCALED_LINE) ? 9'(GLYPH_ROWS) : 9'(2 * GLYPH_ROWS);
      d0_rel    = {1'b0, cmd.pixel_row} - d0_top;
      if (({1'b0, cmd.pixel_row} >= d0_top) && (d0_rel < d0_height)) begin
        d0_text_row = 1'b1;
        d0_line     = LINE_W'(l);
        d0_scale2   = (l != UNSCALED_LINE);
        d0_grow     = (l == UNSCALED_LINE) ? d0_rel[2:0] : d0_rel[3:1];
      end
    end

    // column offset into the line, divided by the cell width via reciprocal
    d0_left_of_text = cmd.pixel_column < text_left;
    d0_off          = cmd.pixel_column - text_left;
    d0_div_in       = d0_scale2 ? {1'b0, d0_off[8:1]} : d0_off;
    d0_prod         = PROD_W'(d0_div_in) * PROD_W'(RECIP_6);
  end

  // stage 1 registers
  logic                   s1_valid;
  logic                   s1_on_screen;
  logic                   s1_in_logo;
  logic [LOGO_ADDR_W-1:0] s1_logo_addr;
  logic                   s1_text_row;
  logic [LINE_W-1:0]      s1_line;
  logic                   s1_scale2;
  logic [2:0]             s1_grow;
  logic                   s1_left_of_text;
  logic [8:0]             s1_off;
  logic [PROD_W-1:0]      s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= cmd_accept && (cmd.opcode == OP_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_on_screen    <= d0_on_screen;
      s1_in_logo      <= d0_in_logo;
      s1_logo_addr    <= d0_logo_addr;
      s1_text_row     <= d0_text_row;
      s1_line         <= d0_line;
      s1_scale2       <= d0_scale2;
      s1_grow         <= d0_grow;
      s1_left_of_text <= d0_left_of_text;
      s1_off          <= d0_off;
      s1_prod         <= d0_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: cell position, line end and right edge checks, store reads
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0]      d1_cell;
  logic [9:0]             d1_cell_x;
  logic [3:0]             d1_within;
  logic [10:0]            d1_x_end;
  logic                   d1_cell_in_line;
  logic                   d1_slots_filled;
  logic                   d1_edge_ok;
  logic                   d1_char_pre;
  logic [LINE_LENGTH-1:0] d1_nz_line;

  always_comb begin
    d1_cell   = s1_prod[PROD_W-1:RECIP_SHIFT];
    // cell * 6, doubled for scaled lines
    d1_cell_x = (10'(d1_cell) << 2) + (10'(d1_cell) << 1);
    if (s1_scale2) begin
      d1_cell_x = d1_cell_x << 1;
    end
    d1_within = 4'(10'(s1_off) - d1_cell_x);
    d1_x_end  = 11'(text_left) + 11'(d1_cell_x)
                + (s1_scale2 ? 11'(2 * GLYPH_COLS) : 11'(GLYPH_COLS));
    d1_edge_ok      = d1_x_end <= 11'(SCREEN_WIDTH);
    d1_cell_in_line = 8'(d1_cell) < 8'(LINE_LENGTH);

    // every slot up to and including this cell must hold a non-zero code
    d1_nz_line      = char_nz[s1_line];
    d1_slots_filled = 1'b1;
    for (int k = 0; k < LINE_LENGTH; k++) begin
      if ((8'(k) <= 8'(d1_cell)) && !d1_nz_line[k]) begin
        d1_slots_filled = 1'b0;
      end
    end

    d1_char_pre = s1_text_row && !s1_left_of_text && d1_cell_in_line
                  && d1_slots_filled && d1_edge_ok;
  end

  // stage 2 registers, memory read data included
  logic        s2_valid;
  logic        s2_on_screen;
  logic        s2_in_logo;
  logic        s2_char_pre;
  logic        s2_scale2;
  logic [2:0]  s2_grow;
  logic [3:0]  s2_within;
  logic [7:0]  s2_code;
  logic [15:0] s2_logo_pix;
  logic [15:0] s2_line_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_on_screen  <= s1_on_screen;
      s2_in_logo    <= s1_in_logo;
      s2_char_pre   <= d1_char_pre;
      s2_scale2     <= s1_scale2;
      s2_grow       <= s1_grow;
      s2_within     <= d1_within;
      s2_code       <= char_mem[{s1_line, d1_cell[SLOT_W-1:0]}];
      s2_logo_pix   <= logo_mem[s1_logo_addr];
      s2_line_color <= line_colors[s1_line];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: font lookup and final colour select
  // ---------------------------------------------------------------------------
  glyph_t      d2_glyph;
  logic [39:0] d2_bits;
  logic [2:0]  d2_col;
  logic [7:0]  d2_column_bits;
  logic        d2_in_glyph;
  logic        d2_lit;
  pixel_t      d2_px;

  always_comb begin
    d2_glyph       = glyph_of(s2_code);
    d2_bits        = glyph_bits(d2_glyph.idx);
    d2_col         = s2_scale2 ? s2_within[3:1] : s2_within[2:0];
    d2_in_glyph    = s2_scale2 ? (s2_within < 4'(2 * GLYPH_COLS))
                               : (s2_within < 4'(GLYPH_COLS));
    d2_column_bits = d2_bits[{d2_col, 3'b000} +: 8];
    d2_lit         = s2_char_pre && d2_in_glyph && d2_glyph.hit && d2_column_bits[s2_grow];

    if (!s2_on_screen) begin
      d2_px.pixel_color  = background_color;
      d2_px.pixel_source = SRC_BACKGROUND;
    end else if (d2_lit) begin
      d2_px.pixel_color  = s2_line_color;
      d2_px.pixel_source = SRC_TEXT;
    end else if (s2_in_logo) begin
      d2_px.pixel_color  = s2_logo_pix;
      d2_px.pixel_source = SRC_LOGO;
    end else begin
      d2_px.pixel_color  = background_color;
      d2_px.pixel_source = SRC_BACKGROUND;
    end
  end

  // stage 3: output register
  pixel_t s3_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_px <= d2_px;
    end
  end

  assign px_valid = s3_valid;
  assign px       = s3_px;

endmodule

// ===== tb/sv/tovl_pixel_checker.sv =====
// tovl_pixel_checker: watches the command, pixel and register ports of the overlay compositor,
// predicts every rendered pixel and compares it with what comes out
// depends on tovl_pkg (cmd_t, pixel_t, opcode, source and register codes, screen sizes)
`timescale 1ns / 100ps

module tovl_pixel_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  tovl_pkg::cmd_t               cmd,
  input  logic                         px_valid,
  input  logic                         px_stall,
  input  tovl_pkg::pixel_t             px,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [tovl_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output int                           errors,
  output int                           pending
);
  import tovl_pkg::*;

  localparam int LOGO_LEFT  = SCREEN_WIDTH - LOGO_WIDTH - 4;
  localparam int SMALL_LINE = 6;
  localparam int TEXT_ROW [7] = '{10, 48, 78, 108, 138, 168, 220};

  // glyph columns, leftmost column in the top byte, bit 0 is the top row
  localparam logic [39:0] FONT5X7 [40] = '{
    40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02, 40'h00_36_36_00_00,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36,
    40'h3E_41_41_41_22, 40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01,
    40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01,
    40'h7F_08_14_22_41, 40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F,
    40'h3E_41_41_41_3E, 40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
    40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F,
    40'h3F_40_38_40_3F, 40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  logic [15:0] bg_colour;
  logic [8:0]  text_x;
  logic [7:0]  logo_y;
  logic [7:0]  char_mem [LINE_COUNT][LINE_LENGTH];
  logic [15:0] line_colour [LINE_COUNT];
  logic [15:0] logo_mem [LOGO_CELLS];
  pixel_t      expected_pixels [$];
  pixel_t      oldest;
  int          fail_count = 0;
  int          pending_count = 0;

  assign errors  = fail_count;
  assign pending = pending_count;

  function automatic int glyph_entry(input logic [7:0] code);
    if (code >= 8'd45 && code <= 8'd47) return int'(code) - 45;
    if (code == 8'd58) return 3;
    if (code >= 8'd48 && code <= 8'd57) return int'(code) - 44;
    if (code >= 8'd65 && code <= 8'd90) return int'(code) - 51;
    return -1;
  endfunction

  function automatic bit line_lit(input int ln, input int row, input int col);
    int scale, y, off, cell_idx, cell_off, x, g;
    logic [7:0] column_bits;
    scale = (ln == SMALL_LINE) ? 1 : 2;
    y = TEXT_ROW[ln];
    if (row < y || row >= y + GLYPH_ROWS * scale) return 1'b0;
    if (col < int'(text_x)) return 1'b0;
    off      = col - int'(text_x);
    cell_idx = off / (CELL_COLS * scale);
    cell_off = off % (CELL_COLS * scale);
    if (cell_idx >= LINE_LENGTH) return 1'b0;
    // the first zero code ends the line
    for (int k = 0; k <= cell_idx; k++) begin
      if (char_mem[ln][k] == 8'd0) return 1'b0;
    end
    x = int'(text_x) + cell_idx * CELL_COLS * scale;
    if (x + GLYPH_COLS * scale > SCREEN_WIDTH) return 1'b0;
    if (cell_off >= GLYPH_COLS * scale) return 1'b0;
    g = glyph_entry(char_mem[ln][cell_idx]);
    if (g < 0) return 1'b0;
    column_bits = FONT5X7[g][39 - 8 * (cell_off / scale) -: 8];
    return column_bits[(row - y) / scale];
  endfunction

  function automatic pixel_t composite_pixel(input logic [7:0] row, input logic [8:0] col);
    pixel_t p;
    int r, c, ln;
    p.pixel_color  = bg_colour;
    p.pixel_source = SRC_BACKGROUND;
    if (row < SCREEN_HEIGHT && col < SCREEN_WIDTH) begin
      r = int'(row) - int'(logo_y);
      c = int'(col) - LOGO_LEFT;
      if (r >= 0 && r < LOGO_HEIGHT && c >= 0 && c < LOGO_WIDTH) begin
        p.pixel_color  = logo_mem[r * LOGO_WIDTH + c];
        p.pixel_source = SRC_LOGO;
      end
      // higher line numbers are drawn last and win
      for (ln = 0; ln < LINE_COUNT; ln++) begin
        if (line_lit(ln, int'(row), int'(col))) begin
          p.pixel_color  = line_colour[ln];
          p.pixel_source = SRC_TEXT;
        end
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      bg_colour = 16'h18E3;
      text_x    = 9'd12;
      logo_y    = 8'd2;
      for (int l = 0; l < LINE_COUNT; l++) begin
        line_colour[l] = 16'd0;
        for (int s = 0; s < LINE_LENGTH; s++) char_mem[l][s] = 8'd0;
      end
      expected_pixels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          {REG_BACKGROUND, 2'b00}: bg_colour = pwdata[15:0];
          {REG_TEXT_LEFT, 2'b00}:  text_x    = pwdata[8:0];
          {REG_LOGO_TOP, 2'b00}:   logo_y    = pwdata[7:0];
          default: ;
        endcase
      end
      // results leave before the transaction of this edge is predicted
      if (px_valid && !px_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel result with nothing outstanding: pixel_color %h pixel_source %0d",
                 px.pixel_color, px.pixel_source);
          fail_count++;
        end else begin
          oldest = expected_pixels.pop_front();
          if (px.pixel_color !== oldest.pixel_color) begin
            $error("pixel_color: expected %h, got %h", oldest.pixel_color, px.pixel_color);
            fail_count++;
          end
          if (px.pixel_source !== oldest.pixel_source) begin
            $error("pixel_source: expected %0d, got %0d", oldest.pixel_source,
                   px.pixel_source);
            fail_count++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        case (opcode_t'(cmd.opcode))
          OP_WRITE_CHAR: begin
            if (cmd.line_number < LINE_COUNT && cmd.char_slot < LINE_LENGTH)
              char_mem[cmd.line_number][cmd.char_slot] = cmd.char_code;
          end
          OP_WRITE_LCOL: begin
            if (cmd.line_number < LINE_COUNT) line_colour[cmd.line_number] = cmd.write_color;
          end
          OP_WRITE_LOGO: begin
            if (cmd.logo_index < LOGO_CELLS) logo_mem[cmd.logo_index] = cmd.write_color;
          end
          default: expected_pixels.push_back(composite_pixel(cmd.pixel_row, cmd.pixel_column));
        endcase
      end
    end
    pending_count = expected_pixels.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// tb_top: stimulus and verdict for text_overlay_pixel_compositor_unit, with random idling on both
// channels and several register settings; depends on tovl_pkg and tovl_pixel_checker
`timescale 1ns / 100ps

module tb_top;
  import tovl_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASES       = 6;
  localparam int SETTLE       = 10;      // pipeline is three deep, leave some margin
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int CMD_BITS     = $bits(cmd_t);
  localparam logic [7:0] END_CODE   = 8'd0;
  localparam logic [7:0] SPACE_CODE = 8'd32;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_stall;
  cmd_t                cmd       = '0;
  logic                px_valid;
  logic                px_stall  = 1'b0;
  pixel_t              px;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  int fail_count;
  int pixels_pending;

  // own copy of the register values, needed to aim stimulus at the logo and text
  logic [8:0]  left_cfg = 9'd12;
  logic [7:0]  top_cfg  = 8'd2;
  bit          logo_loaded [LOGO_CELLS];

  bit quiet;
  int cmds_sent, renders_sent, reg_writes, stall_cycles, stall_left, cycles;

  text_overlay_pixel_compositor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .px_valid  (px_valid),
    .px_stall  (px_stall),
    .px        (px),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tovl_pixel_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .px_valid  (px_valid),
    .px_stall  (px_stall),
    .px        (px),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors    (fail_count),
    .pending   (pixels_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result back-pressure in random bursts, none in the closing stretch
  always @(negedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      px_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_cycles++;
      px_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 11);
      stall_cycles++;
      px_stall <= 1'b1;
    end else begin
      px_stall <= 1'b0;
    end
  end

  // all fields filled with junk first, so unused fields are exercised too
  function automatic cmd_t rand_cmd(input opcode_t op);
    cmd_t c;
    c = cmd_t'(CMD_BITS'({$urandom, $urandom}));
    c.opcode = op;
    return c;
  endfunction

  // one transaction on the command channel; valid stays high afterwards unless a gap follows
  task automatic push_cmd(input cmd_t c);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    cmds_sent++;
  endtask

  task automatic put_char(input int ln, input int slot, input logic [7:0] code);
    cmd_t c;
    c = rand_cmd(OP_WRITE_CHAR);
    c.line_number = 3'(ln);
    c.char_slot   = 5'(slot);
    c.char_code   = code;
    push_cmd(c);
  endtask

  task automatic put_colour(input int ln, input logic [15:0] colour);
    cmd_t c;
    c = rand_cmd(OP_WRITE_LCOL);
    c.line_number = 3'(ln);
    c.write_color = colour;
    push_cmd(c);
  endtask

  task automatic put_logo(input int idx, input logic [15:0] colour);
    cmd_t c;
    c = rand_cmd(OP_WRITE_LOGO);
    c.logo_index  = 11'(idx);
    c.write_color = colour;
    logo_loaded[idx] = 1'b1;
    push_cmd(c);
  endtask

  // a logo pixel is only ever read after it has been loaded
  task automatic render(input logic [7:0] row, input logic [8:0] col);
    cmd_t c;
    int r, k;
    if (row < SCREEN_HEIGHT && col < SCREEN_WIDTH) begin
      r = int'(row) - int'(top_cfg);
      k = int'(col) - LOGO_X;
      if (r >= 0 && r < LOGO_HEIGHT && k >= 0 && k < LOGO_WIDTH &&
          !logo_loaded[r * LOGO_WIDTH + k])
        put_logo(r * LOGO_WIDTH + k, 16'($urandom));
    end
    c = rand_cmd(OP_RENDER);
    c.pixel_row    = row;
    c.pixel_column = col;
    push_cmd(c);
    renders_sent++;
  endtask

  task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
  endtask

  // sender holds off until every outstanding pixel is back and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pixels_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] bg, input logic [8:0] left,
                           input logic [7:0] top);
    drain();
    reg_write(REG_BACKGROUND, 32'(bg));
    reg_write(REG_TEXT_LEFT, 32'(left));
    reg_write(REG_LOGO_TOP, 32'(top));
    left_cfg = left;
    top_cfg  = top;
  endtask

  // mostly font characters; spaces, line ends and arbitrary codes now and then
  function automatic logic [7:0] pick_code(input bit allow_end);
    int s, k;
    s = $urandom_range(0, 9);
    if (allow_end && s == 0) return END_CODE;
    if (s == 1) return SPACE_CODE;
    if (s == 2) return 8'($urandom_range(0, 255));
    k = $urandom_range(0, 39);
    if (k < 3) return 8'(45 + k);   // - . /
    if (k == 3) return 8'd58;       // colon
    if (k < 14) return 8'(44 + k);  // digits
    return 8'(51 + k);              // capitals
  endfunction

  task automatic random_render();
    int sel, ln, scale;
    logic [7:0] row;
    logic [8:0] col;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      // inside a text band, anywhere along the line
      ln    = $urandom_range(0, LINE_COUNT - 1);
      scale = (ln == UNSCALED_LINE) ? 1 : 2;
      row   = 8'(int'(LINE_FIRST_ROW[ln]) + $urandom_range(0, GLYPH_ROWS * scale - 1));
      col   = 9'(int'(left_cfg) + $urandom_range(0, LINE_LENGTH * CELL_COLS * scale - 1));
    end else if (sel < 70) begin
      row = 8'(int'(top_cfg) + $urandom_range(0, LOGO_HEIGHT - 1));
      col = 9'(LOGO_X + $urandom_range(0, LOGO_WIDTH - 1));
    end else if (sel < 78) begin
      // off the screen on one axis or both
      row = 8'($urandom_range(0, 255));
      col = 9'($urandom_range(SCREEN_WIDTH, 511));
      if ($urandom_range(0, 1) == 1) begin
        row = 8'($urandom_range(SCREEN_HEIGHT, 255));
        col = 9'($urandom_range(0, 511));
      end
    end else begin
      row = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
      col = 9'($urandom_range(0, SCREEN_WIDTH - 1));
    end
    render(row, col);
  endtask

  task automatic random_action();
    int sel, ln, n;
    sel = $urandom_range(0, 99);
    if (sel < 4) begin
      // a whole string into one line, ended unless it fills the line
      ln = $urandom_range(0, LINE_COUNT - 1);
      n  = $urandom_range(1, LINE_LENGTH);
      for (int s = 0; s < n; s++) put_char(ln, s, pick_code(1'b0));
      if (n < LINE_LENGTH) put_char(ln, n, END_CODE);
    end else if (sel < 60) begin
      random_render();
    end else if (sel < 80) begin
      ln = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, LINE_COUNT - 1);
      n  = ($urandom_range(0, 9) == 0) ? $urandom_range(LINE_LENGTH, 31)
                                       : $urandom_range(0, LINE_LENGTH - 1);
      put_char(ln, n, pick_code(1'b1));
    end else if (sel < 88) begin
      put_colour($urandom_range(0, 7), 16'($urandom));
    end else begin
      put_logo($urandom_range(0, LOGO_CELLS - 1), 16'($urandom));
    end
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset register values
    render(8'd0, 9'd0);                      // empty lines, background only
    put_colour(0, 16'hFFFF);
    put_colour(6, 16'h0000);
    put_colour(7, 16'h1234);                 // no such line, ignored
    put_char(0, 0, 8'd65);                   // A
    put_char(0, 1, 8'd45);                   // lowest font code
    put_char(0, 2, 8'd58);                   // colon
    put_char(0, 3, SPACE_CODE);
    put_char(0, 4, 8'd90);                   // highest font code
    put_char(0, 5, END_CODE);
    put_char(0, 6, 8'd48);                   // hidden behind the line end
    put_char(6, 0, 8'd57);
    put_char(6, 1, 8'd44);                   // just below the font range, draws nothing
    put_char(7, 0, 8'd65);                   // line out of range
    put_char(1, 31, 8'd65);                  // slot out of range
    put_logo(0, 16'h0000);
    put_logo(LOGO_CELLS - 1, 16'hFFFF);
    render(8'd12, 9'd12);                    // lit pixel of A, scaled line
    render(8'd10, 9'd60);                    // top row of Z
    render(8'd12, 9'd84);                    // cell after the line end
    render(8'd221, 9'd12);                   // unscaled line, colour zero
    render(8'd2, 9'(LOGO_X));                // logo corners
    render(8'd33, 9'(LOGO_X + LOGO_WIDTH - 1));
    render(8'd239, 9'd319);                  // last on-screen pixel
    render(8'd255, 9'd511);                  // off screen both ways

    // random part over several register settings, extremes among them
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(16'($urandom), 9'd0, 8'd0);
        1: configure(16'hFFFF, 9'd319, 8'd239);
        2: configure(16'h0000, 9'($urandom_range(0, 40)), 8'($urandom_range(0, 239)));
        3: configure(16'($urandom), 9'($urandom_range(200, 300)), 8'($urandom_range(0, 239)));
        4: configure(16'($urandom), 9'($urandom_range(0, 319)), 8'($urandom_range(0, 239)));
        default: configure(16'h18E3, 9'd12, 8'd2);
      endcase
      target = cmds_sent + RANDOM_ITEMS / PHASES;
      while (cmds_sent < target) begin
        // closing stretch runs at full rate on both sides
        if (p == PHASES - 1 && cmds_sent > target - RANDOM_ITEMS / (2 * PHASES)) quiet = 1'b1;
        random_action();
      end
    end

    drain();
    $display("run covered %0d transactions, %0d of them pixel renders, over %0d register writes",
             cmds_sent, renders_sent, reg_writes);
    $display("result channel was held back on %0d cycles", stall_cycles);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
